// ----- hdl/i2crts_pkg.sv -----
// Package: shared types, codes and sizes for the I2C register transaction sequencer.
package i2crts_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // result buffer; pointers wrap naturally, so keep the depth a power of two
  localparam int RBUF_DEPTH = 4;
  localparam int RBUF_PTR_W = $clog2(RBUF_DEPTH);
  localparam int RBUF_CNT_W = $clog2(RBUF_DEPTH + 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_SEND      = 3'd2;
  localparam logic [2:0] ACT_RECV_NACK = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ADDR   = 4'd1,
    PH_REG    = 4'd2,
    PH_RSTART = 4'd3,
    PH_RADDR  = 4'd4,
    PH_RECV   = 4'd6,
    PH_DATA   = 4'd7,
    PH_STOP   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] dev_address;
    logic [7:0] reg_address;
    logic [7:0] write_value;
  } req_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic       transfer_done;
    logic       request_queued;
    logic       request_dropped;
    logic       busy_res;
    logic       last;
  } rsp_t;

  // one pending transaction: 25 bits
  typedef struct packed {
    logic       is_read;
    logic [7:0] device;
    logic [7:0] reg_num;
    logic [7:0] value;
  } xact_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // results of one step: one or two beats
  typedef struct packed {
    logic valid;
    logic two;
    rsp_t r0;
    rsp_t r1;
  } res_pair_t;

endpackage

// ----- hdl/i2c_register_transaction_sequencer.sv -----
// Top level of the I2C register transaction sequencer.
//   channel | direction | payload | beats per item
//   req     | in        | req_t   | 1
//   rsp     | out       | rsp_t   | 1 or 2 (stop plus chained start)
// A request beat is registered in the input stage, decoded once the result buffer
// has room and written into that four-entry buffer, which drives rsp_valid; one
// item per cycle while rsp_ready keeps up; two-result items go out as two beats.
// req_ready drops only when the input stage holds a beat and the result buffer has
// fewer than two free entries. Synchronous reset empties all queues, phase idle.
module i2c_register_transaction_sequencer import i2crts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic      stage_valid;
  req_t      stage;
  logic      room;
  logic      fire;
  q_ctrl_t   q_ctrl;
  q_status_t q_status;
  xact_t     q_wdata;
  xact_t     q_head;
  res_pair_t res;

  assign fire      = stage_valid && room;
  assign req_ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stage <= req;
    end
  end

  i2crts_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (q_ctrl),
    .wdata  (q_wdata),
    .head   (q_head),
    .status (q_status)
  );

  i2crts_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (stage),
    .q_status (q_status),
    .q_head   (q_head),
    .q_ctrl   (q_ctrl),
    .q_wdata  (q_wdata),
    .res      (res)
  );

  i2crts_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .wr        (res),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- hdl/i2crts_queue.sv -----
// Pending transaction FIFO.
module i2crts_queue import i2crts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_ctrl_t   ctrl,
  input  xact_t     wdata,
  output xact_t     head,
  output q_status_t status
);

  xact_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) wr_ptr <= ptr_inc(wr_ptr);
      if (ctrl.pop)  rd_ptr <= ptr_inc(rd_ptr);
      // push and pop never come from the same step
      if (ctrl.push && !ctrl.pop)      count <= count + 1'b1;
      else if (ctrl.pop && !ctrl.push) count <= count - 1'b1;
    end
  end

  assign head         = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));

endmodule

// ----- hdl/i2crts_seq.sv -----
// Transaction phase sequencer: decodes one registered beat into its bus actions.
module i2crts_seq import i2crts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  req_t      item,
  input  q_status_t q_status,
  input  xact_t     q_head,
  output q_ctrl_t   q_ctrl,
  output xact_t     q_wdata,
  output res_pair_t res
);

  phase_t phase, phase_next;
  xact_t  cur, cur_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cur   <= '0;
    end else begin
      phase <= phase_next;
      cur   <= cur_next;
    end
  end

  always_comb begin
    xact_t req_x;
    rsp_t  r0;
    rsp_t  r1;
    logic  two;
    logic  busy;

    req_x.is_read = (item.cmd == CMD_READ);
    req_x.device  = item.dev_address;
    req_x.reg_num = item.reg_address;
    req_x.value   = (item.cmd == CMD_READ) ? 8'd0 : item.write_value;

    phase_next = phase;
    cur_next   = cur;
    q_ctrl     = '0;
    q_wdata    = req_x;
    r0         = '0;
    r1         = '0;
    two        = 1'b0;

    if (fire) begin
      case (item.cmd)
        CMD_WRITE, CMD_READ: begin
          if (phase == PH_IDLE) begin
            cur_next      = req_x;
            phase_next    = PH_ADDR;
            r0.bus_action = ACT_START;
          end else if (!q_status.full) begin
            q_ctrl.push       = 1'b1;
            r0.request_queued = 1'b1;
          end else begin
            r0.request_dropped = 1'b1;
          end
        end
        CMD_STEP: begin
          case (phase)
            PH_ADDR: begin
              phase_next    = PH_REG;
              r0.bus_action = ACT_SEND;
              r0.bus_byte   = cur.device;
            end
            PH_REG: begin
              phase_next    = cur.is_read ? PH_RSTART : PH_DATA;
              r0.bus_action = ACT_SEND;
              r0.bus_byte   = cur.reg_num;
            end
            PH_RSTART: begin
              phase_next    = PH_RADDR;
              r0.bus_action = ACT_START;
            end
            PH_RADDR: begin
              phase_next    = PH_RECV;
              r0.bus_action = ACT_SEND;
              r0.bus_byte   = cur.device + 8'd1;
            end
            PH_RECV: begin
              phase_next    = PH_STOP;
              r0.bus_action = ACT_RECV_NACK;
            end
            PH_DATA: begin
              phase_next    = PH_STOP;
              r0.bus_action = ACT_SEND;
              r0.bus_byte   = cur.value;
            end
            PH_STOP: begin
              r0.bus_action    = ACT_STOP;
              r0.transfer_done = 1'b1;
              if (!q_status.empty) begin
                // chain straight into the oldest pending transaction
                q_ctrl.pop    = 1'b1;
                cur_next      = q_head;
                phase_next    = PH_ADDR;
                r1.bus_action = ACT_START;
                two           = 1'b1;
              end else begin
                phase_next = PH_IDLE;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end

    busy        = (phase_next != PH_IDLE);
    r0.busy_res = busy;
    r1.busy_res = busy;
    r0.last     = !two;
    r1.last     = 1'b1;

    res.valid = fire;
    res.two   = two;
    res.r0    = r0;
    res.r1    = r1;
  end

endmodule

// ----- hdl/i2crts_outbuf.sv -----
// Result buffer: one or two beats in per cycle, one out when rsp_ready.
module i2crts_outbuf import i2crts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t wr,
  output logic      room,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_t      rsp
);

  rsp_t                  mem [RBUF_DEPTH];
  logic [RBUF_PTR_W-1:0] rd_ptr;
  logic [RBUF_PTR_W-1:0] wr_ptr;
  logic [RBUF_CNT_W-1:0] count;
  logic                  pop;
  logic [RBUF_CNT_W-1:0] n_in;

  assign pop  = rsp_valid && rsp_ready;
  assign n_in = !wr.valid ? '0 : (wr.two ? RBUF_CNT_W'(2) : RBUF_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr_ptr] <= wr.r0;
      if (wr.two) mem[wr_ptr + RBUF_PTR_W'(1)] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_in[RBUF_PTR_W-1:0];
      if (pop) rd_ptr <= rd_ptr + RBUF_PTR_W'(1);
      count <= count + n_in - RBUF_CNT_W'(pop);
    end
  end

  assign rsp_valid = (count != '0);
  assign rsp       = mem[rd_ptr];
  // space for the worst case of two beats
  assign room      = (count <= RBUF_CNT_W'(RBUF_DEPTH - 2));

endmodule

// ----- hdl/i2crts_checker.sv -----
// Port-level checks for the sequencer, bound to the top level.
module i2crts_checker import i2crts_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

  a_byte_only_on_send: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bus_byte != 8'd0 |-> rsp.bus_action == ACT_SEND)
    else $error("bus_byte set on a non-send action");

  a_done_on_stop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.transfer_done |-> rsp.bus_action == ACT_STOP && !rsp.request_queued)
    else $error("transfer_done without stop");

  // the only two-beat item is a stop that chains into a queued start
  a_first_of_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp.last |=>
      rsp_valid && rsp.bus_action == ACT_START && rsp.last && rsp.busy_res)
    else $error("bad two-beat result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.request_queued || rsp.request_dropped) |->
      rsp.bus_action == ACT_NONE && !(rsp.request_queued && rsp.request_dropped))
    else $error("queue flags with a bus action");

endmodule

bind i2c_register_transaction_sequencer i2crts_checker u_i2crts_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ----- tb/sv/i2c_register_transaction_sequencer_tb.sv -----
// Testbench for the I2C register transaction sequencer: directed and random beats, scoreboard.
`timescale 1ns / 100ps

module i2c_register_transaction_sequencer_tb;
  import i2crts_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  i2c_register_transaction_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus backlog and expected bus actions
  req_t req_backlog[$];
  rsp_t due_actions[$];

  int req_idle_pct = 0;
  int rsp_idle_pct = 0;
  int beats_offered = 0;
  int beats_accepted = 0;
  int rsp_beats = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int xacts_done = 0;
  int chained_starts = 0;
  int drops_seen = 0;

  // sequencer state mirror
  phase_t m_phase = PH_IDLE;
  logic m_active = 1'b0;
  xact_t m_cur = '0;
  xact_t xact_fifo[$];

  task automatic sequencer_step(input req_t r);
    rsp_t first;
    rsp_t second;
    logic two;
    first = '0;
    second = '0;
    two = 1'b0;
    case (r.cmd)
      CMD_WRITE, CMD_READ: begin
        xact_t x;
        x.is_read = (r.cmd == CMD_READ);
        x.device = r.dev_address;
        x.reg_num = r.reg_address;
        x.value = x.is_read ? 8'd0 : r.write_value;
        if (!m_active) begin
          m_cur = x;
          m_phase = PH_ADDR;
          m_active = 1'b1;
          first.bus_action = ACT_START;
        end else if (xact_fifo.size() < QUEUE_DEPTH) begin
          xact_fifo.push_back(x);
          first.request_queued = 1'b1;
        end else begin
          first.request_dropped = 1'b1;
          drops_seen++;
        end
      end
      CMD_STEP: begin
        case (m_phase)
          PH_ADDR: begin
            m_phase = PH_REG;
            first.bus_action = ACT_SEND;
            first.bus_byte = m_cur.device;
          end
          PH_REG: begin
            m_phase = m_cur.is_read ? PH_RSTART : PH_DATA;
            first.bus_action = ACT_SEND;
            first.bus_byte = m_cur.reg_num;
          end
          PH_RSTART: begin
            m_phase = PH_RADDR;
            first.bus_action = ACT_START;
          end
          PH_RADDR: begin
            m_phase = PH_RECV;
            first.bus_action = ACT_SEND;
            first.bus_byte = m_cur.device + 8'd1;  // read address wraps
          end
          PH_RECV: begin
            m_phase = PH_STOP;
            first.bus_action = ACT_RECV_NACK;
          end
          PH_DATA: begin
            m_phase = PH_STOP;
            first.bus_action = ACT_SEND;
            first.bus_byte = m_cur.value;
          end
          PH_STOP: begin
            first.bus_action = ACT_STOP;
            first.transfer_done = 1'b1;
            xacts_done++;
            if (xact_fifo.size() != 0) begin
              m_cur = xact_fifo.pop_front();
              m_phase = PH_ADDR;
              second.bus_action = ACT_START;
              two = 1'b1;
              chained_starts++;
            end else begin
              m_phase = PH_IDLE;
              m_active = 1'b0;
            end
          end
          default: begin
            // step with nothing in flight: forced idle
            m_phase = PH_IDLE;
            m_active = 1'b0;
          end
        endcase
      end
      default: ;
    endcase
    first.busy_res = m_active;
    second.busy_res = m_active;
    if (two) begin
      second.last = 1'b1;
      due_actions.push_back(first);
      due_actions.push_back(second);
    end else begin
      first.last = 1'b1;
      due_actions.push_back(first);
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      if (!req_valid || beats_accepted == beats_offered) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
          req_valid <= 1'b1;
          req <= req_backlog.pop_front();
          beats_offered++;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on accepted request beats, check response beats
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        sequencer_step(req);
        beats_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_beats++;
        if (due_actions.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected response beat, expected none got %0h", $time, rsp);
        end else begin
          want = due_actions.pop_front();
          cmp_field("bus_action", 8'(want.bus_action), 8'(rsp.bus_action));
          cmp_field("bus_byte", want.bus_byte, rsp.bus_byte);
          cmp_field("transfer_done", 8'(want.transfer_done), 8'(rsp.transfer_done));
          cmp_field("request_queued", 8'(want.request_queued), 8'(rsp.request_queued));
          cmp_field("request_dropped", 8'(want.request_dropped), 8'(rsp.request_dropped));
          cmp_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
          cmp_field("last", 8'(want.last), 8'(rsp.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               due_actions.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_req(input logic [1:0] cmd, input logic [7:0] dev, input logic [7:0] regn,
                         input logic [7:0] val);
    req_t r;
    r.cmd = cmd;
    r.dev_address = dev;
    r.reg_address = regn;
    r.write_value = val;
    req_backlog.push_back(r);
  endtask

  // bursts with a varying request density: sparse bursts run transactions to
  // completion, dense ones fill the pending queue and force drops
  task automatic add_random(input int n);
    int req_pct;
    int left;
    int roll;
    logic [1:0] cmd;
    left = n;
    while (left > 0) begin
      case ($urandom_range(2))
        0: req_pct = 6;
        1: req_pct = 20;
        default: req_pct = 45;
      endcase
      for (int i = 0; i < 50 && left > 0; i++) begin
        roll = $urandom_range(99);
        if (roll < 3)
          cmd = CMD_UNUSED;
        else if (roll < 3 + req_pct)
          cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
        else
          cmd = CMD_STEP;
        add_req(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
        if (cmd != CMD_UNUSED)
          left--;
      end
    end
  endtask

  // sender holds off until every expected beat is back
  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_valid || due_actions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    req_idle_pct = 28;
    rsp_idle_pct = 58;
    add_req(CMD_STEP, 8'h00, 8'h00, 8'h00);    // step while idle
    add_req(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    add_req(CMD_WRITE, 8'hFF, 8'h00, 8'hFF);
    add_req(CMD_READ, 8'hFF, 8'hFF, 8'hAA);    // queued, read address wraps later
    for (int i = 0; i < 7; i++)
      add_req((i % 2) ? CMD_READ : CMD_WRITE, 8'(i * 37), 8'(255 - i * 29), 8'(i * 51));
    add_req(CMD_WRITE, 8'h00, 8'hFF, 8'h00);   // queue full: dropped
    repeat (10) add_req(CMD_STEP, 8'h00, 8'h00, 8'h00);
    add_random(630);
    wait_drained();

    req_idle_pct = 58;
    rsp_idle_pct = 28;
    add_random(650);
    wait_drained();

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    add_random(650);
    wait_drained();

    $display("sent %0d request beats, checked %0d response beats in %0d cycles",
             beats_accepted, rsp_beats, cycle_count);
    $display("%0d transactions stopped, %0d chained starts, %0d requests dropped",
             xacts_done, chained_starts, drops_seen);
    if (mismatch_count == 0 && due_actions.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/i2crts_pkg.sv
hdl/i2crts_queue.sv
hdl/i2crts_seq.sv
hdl/i2crts_outbuf.sv
hdl/i2c_register_transaction_sequencer.sv
hdl/i2crts_checker.sv
tb/sv/i2c_register_transaction_sequencer_tb.sv
